[hdl/assert_macros.svh]
// assertion helpers included by lse_ctrl
// each macro expects i_clk and i_rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is held
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is held
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/lse_pkg.sv]
// ----------------------------------------------------------------------------
// lse_pkg
// types, codes and defaults shared by the lifo stack engine
// ----------------------------------------------------------------------------
`default_nettype none

package lse_pkg;

    localparam int unsigned STACK_DEPTH_DEF = 32;
    localparam int unsigned VAL_W           = 31;
    localparam int unsigned KIND_W          = 3;

    typedef logic [VAL_W-1:0]  t_value;
    typedef logic [KIND_W-1:0] t_kind;

    localparam t_kind KIND_PUSH = 3'd0;
    localparam t_kind KIND_POP  = 3'd1;
    localparam t_kind KIND_SWAP = 3'd2;
    localparam t_kind KIND_PEEK = 3'd3;
    localparam t_kind KIND_DUMP = 3'd4;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_PUSH_USAGE = 3'd1,
        ST_PEEK_EMPTY = 3'd2,
        ST_POP_EMPTY  = 3'd3,
        ST_SWAP_SHORT = 3'd4,
        ST_FULL       = 3'd5,
        ST_HALTED     = 3'd6
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_DUMP
    } t_state;

    // operation applied to the whole cell chain, all cells together
    typedef enum logic [2:0] {
        OP_HOLD,
        OP_PUSH,
        OP_POP,
        OP_SWAP,
        OP_ROT
    } t_chain_op;

    // per-cell load source
    typedef enum logic [1:0] {
        SEL_HOLD,
        SEL_PREV,
        SEL_NEXT,
        SEL_TOP
    } t_cell_sel;

    typedef struct packed {
        t_chain_op op;
        t_value    push_value;
    } t_chain_cmd;

endpackage

`default_nettype wire

[hdl/lse_cell.sv]
// ----------------------------------------------------------------------------
// lse_cell
// one stack slot; loads from its upper or lower neighbor, the top, or holds
// ----------------------------------------------------------------------------
`default_nettype none

module lse_cell (
    input  wire logic              i_clk,
    input  wire lse_pkg::t_cell_sel i_sel,
    input  wire lse_pkg::t_value   i_prev,
    input  wire lse_pkg::t_value   i_next,
    input  wire lse_pkg::t_value   i_top,
    output lse_pkg::t_value        o_data
);

    lse_pkg::t_value r_data;
    lse_pkg::t_value n_data;

    always_comb begin
        case (i_sel)
            lse_pkg::SEL_PREV: n_data = i_prev;
            lse_pkg::SEL_NEXT: n_data = i_next;
            lse_pkg::SEL_TOP:  n_data = i_top;
            default:           n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

[hdl/lse_ctrl.sv]
// ----------------------------------------------------------------------------
// lse_ctrl
// decodes items, keeps element count and halt flag, sequences dumps and
// holds the result register
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module lse_ctrl #(
    parameter int unsigned STACK_DEPTH = lse_pkg::STACK_DEPTH_DEF,
    parameter int unsigned CW          = $clog2(STACK_DEPTH + 1)
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire lse_pkg::t_kind  i_kind,
    input  wire lse_pkg::t_value i_push_value,
    input  wire logic            i_operand_ok,
    input  wire lse_pkg::t_value i_top,
    output lse_pkg::t_chain_cmd  o_cmd,
    output logic [CW-1:0]        o_wrap_idx,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output lse_pkg::t_status     o_status,
    output lse_pkg::t_value      o_read_value,
    output logic                 o_last
);

    localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);
    localparam logic [CW-1:0] TWO_C   = CW'(2);

    lse_pkg::t_state  r_state,     n_state;
    logic [CW-1:0]    r_count,     n_count;
    logic [CW-1:0]    r_dump_left, n_dump_left;
    logic             r_halted,    n_halted;
    logic             r_out_valid, n_out_valid;
    lse_pkg::t_status r_out_status, n_out_status;
    lse_pkg::t_value  r_out_value,  n_out_value;
    logic             r_out_last,   n_out_last;

    logic out_free;
    logic in_acc;

    assign out_free = !r_out_valid || i_ready;
    assign o_ready  = (r_state == lse_pkg::S_IDLE) && out_free;
    assign in_acc   = i_valid && o_ready;

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_dump_left  = r_dump_left;
        n_halted     = r_halted;
        n_out_valid  = r_out_valid && !i_ready;
        n_out_status = r_out_status;
        n_out_value  = r_out_value;
        n_out_last   = r_out_last;
        o_cmd.op         = lse_pkg::OP_HOLD;
        o_cmd.push_value = i_push_value;

        case (r_state)
            lse_pkg::S_IDLE: begin
                if (in_acc) begin
                    // default result: one item, no value, last set
                    n_out_status = lse_pkg::ST_OK;
                    n_out_value  = '0;
                    n_out_last   = 1'b1;
                    if (r_halted) begin
                        n_out_valid  = 1'b1;
                        n_out_status = lse_pkg::ST_HALTED;
                    end else begin
                        case (i_kind)
                            lse_pkg::KIND_PUSH: begin
                                n_out_valid = 1'b1;
                                if (!i_operand_ok) begin
                                    n_out_status = lse_pkg::ST_PUSH_USAGE;
                                    n_count      = '0;
                                    n_halted     = 1'b1;
                                end else if (r_count == DEPTH_C) begin
                                    n_out_status = lse_pkg::ST_FULL;
                                end else begin
                                    o_cmd.op = lse_pkg::OP_PUSH;
                                    n_count  = r_count + ONE_C;
                                end
                            end
                            lse_pkg::KIND_POP: begin
                                n_out_valid = 1'b1;
                                if (r_count == '0) begin
                                    n_out_status = lse_pkg::ST_POP_EMPTY;
                                    n_halted     = 1'b1;
                                end else begin
                                    o_cmd.op = lse_pkg::OP_POP;
                                    n_count  = r_count - ONE_C;
                                end
                            end
                            lse_pkg::KIND_SWAP: begin
                                n_out_valid = 1'b1;
                                if (r_count < TWO_C) begin
                                    n_out_status = lse_pkg::ST_SWAP_SHORT;
                                    n_count      = '0;
                                    n_halted     = 1'b1;
                                end else begin
                                    o_cmd.op = lse_pkg::OP_SWAP;
                                end
                            end
                            lse_pkg::KIND_PEEK: begin
                                n_out_valid = 1'b1;
                                if (r_count == '0) begin
                                    n_out_status = lse_pkg::ST_PEEK_EMPTY;
                                end else begin
                                    n_out_value = i_top;
                                end
                            end
                            lse_pkg::KIND_DUMP: begin
                                // empty stack gives no result
                                if (r_count != '0) begin
                                    n_state     = lse_pkg::S_DUMP;
                                    n_dump_left = r_count;
                                end
                            end
                            default: begin
                                n_out_valid = r_out_valid && !i_ready;
                            end
                        endcase
                    end
                end
            end
            lse_pkg::S_DUMP: begin
                if (out_free) begin
                    // emit top, rotate it to the bottom of the live region
                    n_out_valid  = 1'b1;
                    n_out_status = lse_pkg::ST_OK;
                    n_out_value  = i_top;
                    n_out_last   = (r_dump_left == ONE_C);
                    o_cmd.op     = lse_pkg::OP_ROT;
                    n_dump_left  = r_dump_left - ONE_C;
                    if (r_dump_left == ONE_C) begin
                        n_state = lse_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = lse_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lse_pkg::S_IDLE;
            r_count     <= '0;
            r_dump_left <= '0;
            r_halted    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_dump_left <= n_dump_left;
            r_halted    <= n_halted;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_status <= n_out_status;
        r_out_value  <= n_out_value;
        r_out_last   <= n_out_last;
    end

    assign o_wrap_idx   = r_count - ONE_C;
    assign o_valid      = r_out_valid;
    assign o_status     = r_out_status;
    assign o_read_value = r_out_value;
    assign o_last       = r_out_last;

    `ASSERT_IMPL(a_count_bound, 1'b1, r_count <= DEPTH_C, "element count above depth")
    `ASSERT_IMPL(a_halt_empty, r_halted, r_count == '0, "halted with live elements")
    `ASSERT_IMPL(a_dump_range, r_state == lse_pkg::S_DUMP,
        (r_dump_left != '0) && (r_dump_left <= r_count), "dump counter out of range")
    `ASSERT_NEXT(a_halt_report, in_acc && r_halted,
        r_out_valid && (r_out_status == lse_pkg::ST_HALTED), "halted item not reported")
    `ASSERT_NEXT(a_halt_sticky, r_halted, r_halted, "halt flag dropped without reset")

endmodule

`default_nettype wire

[hdl/lifo_stack_engine_top.sv]
// ----------------------------------------------------------------------------
// lifo_stack_engine_top: bounded lifo stack built as a chain of shift cells
// push/pop/swap/peek: result is registered, valid in the cycle after accept
// dump of n elements: n results, one per cycle unless i_ready stalls, rotating
// reset: empty stack, not halted; slot contents are not cleared
// ----------------------------------------------------------------------------
`default_nettype none

module lifo_stack_engine_top #(
    parameter int unsigned STACK_DEPTH = lse_pkg::STACK_DEPTH_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [lse_pkg::KIND_W-1:0]   i_kind,
    input  wire logic [lse_pkg::VAL_W-1:0]    i_push_value,
    input  wire logic                         i_operand_ok,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic [2:0]                        o_status,
    output logic [lse_pkg::VAL_W-1:0]         o_read_value,
    output logic                              o_last
);

    localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

    lse_pkg::t_chain_cmd cmd;
    logic [CW-1:0]       wrap_idx;
    lse_pkg::t_status    status;
    lse_pkg::t_value     cell_data [STACK_DEPTH];

    lse_ctrl #(
        .STACK_DEPTH (STACK_DEPTH),
        .CW          (CW)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_kind       (i_kind),
        .i_push_value (i_push_value),
        .i_operand_ok (i_operand_ok),
        .i_top        (cell_data[0]),
        .o_cmd        (cmd),
        .o_wrap_idx   (wrap_idx),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_status     (status),
        .o_read_value (o_read_value),
        .o_last       (o_last)
    );

    assign o_status = status;

    // slot 0 is the top of stack
    for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
        lse_pkg::t_cell_sel sel;
        lse_pkg::t_value    prev_data;
        lse_pkg::t_value    next_data;

        if (i == 0) begin : g_first
            assign prev_data = cmd.push_value;
        end else begin : g_mid
            assign prev_data = cell_data[i-1];
        end

        if (i == STACK_DEPTH - 1) begin : g_last
            assign next_data = '0;
        end else begin : g_inner
            assign next_data = cell_data[i+1];
        end

        always_comb begin
            case (cmd.op)
                lse_pkg::OP_PUSH: sel = lse_pkg::SEL_PREV;
                lse_pkg::OP_POP:  sel = lse_pkg::SEL_NEXT;
                lse_pkg::OP_SWAP: begin
                    if (i == 0) begin
                        sel = lse_pkg::SEL_NEXT;
                    end else if (i == 1) begin
                        sel = lse_pkg::SEL_PREV;
                    end else begin
                        sel = lse_pkg::SEL_HOLD;
                    end
                end
                lse_pkg::OP_ROT: begin
                    // top wraps into the deepest live slot
                    if (CW'(i) < wrap_idx) begin
                        sel = lse_pkg::SEL_NEXT;
                    end else if (CW'(i) == wrap_idx) begin
                        sel = lse_pkg::SEL_TOP;
                    end else begin
                        sel = lse_pkg::SEL_HOLD;
                    end
                end
                default: sel = lse_pkg::SEL_HOLD;
            endcase
        end

        lse_cell u_cell (
            .i_clk  (i_clk),
            .i_sel  (sel),
            .i_prev (prev_data),
            .i_next (next_data),
            .i_top  (cell_data[0]),
            .o_data (cell_data[i])
        );
    end

endmodule

`default_nettype wire
